@@ src/speq_pkg.sv @@
// Package: sizes, command and status codes, edge and control types for the edge queue.
`timescale 1ns / 1ps
`default_nettype none
package speq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int NODE_W = 8;
  localparam int WGT_W  = 16;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;
  localparam int IN_W   = 40;
  localparam int OUT_W  = 40;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP_MIN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_NODE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        [NODE_W-1:0] a;
    logic        [NODE_W-1:0] b;
    logic signed [WGT_W-1:0]  w;
  } edge_t;

  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              pop_min;
    edge_t             item;
    logic [NODE_W-1:0] sn;
  } ctl_t;

endpackage
`default_nettype wire

@@ src/sorted_edge_priority_queue.sv @@
// Top level: sorted edge queue built from a row of shifting cells, with an output register.
//
//  channel | dir | tdata (low bit up)                      | tuser
//  s_*     | in  | node_a, node_b, edge_weight, search_node | command
//  m_*     | out | out_a, out_b, out_weight, fill          | status
//
// One word per cycle while the output is not stalled: every cell compares in parallel
// and the row shifts in the same edge; the result lands in the output register in the
// cycle after accept. A new word is taken whenever the output register is empty or
// being drained. Reset empties the queue and the output register; slot contents are
// not cleared. A stalled output holds its word.
`timescale 1ns / 1ps
`default_nettype none
module sorted_edge_priority_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [speq_pkg::IN_W-1:0]   s_tdata,  // node_a, node_b, edge_weight, search_node
  input  wire logic [speq_pkg::CMD_W-1:0]  s_tuser,  // command
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [speq_pkg::OUT_W-1:0]       m_tdata,  // out_a, out_b, out_weight, fill, zero pad
  output logic [speq_pkg::STAT_W-1:0]      m_tuser   // status
);
  import speq_pkg::*;

  logic              accept;
  logic              full;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  ctl_t              ctl;
  logic [DEPTH:0]    ge_c;
  logic [DEPTH:0]    seen_c;
  edge_t             found_c [DEPTH+1];
  edge_t             slot    [DEPTH];
  edge_t             res_edge;
  logic [STAT_W-1:0] res_stat;
  logic [FILL_W-1:0] res_fill;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(DEPTH));

  always_comb begin
    ctl.ins     = accept && (s_tuser == CMD_INSERT) && !full;
    ctl.rem     = accept && (s_tuser == CMD_POP_MIN || s_tuser == CMD_POP_NODE);
    ctl.pop_min = (s_tuser == CMD_POP_MIN);
    ctl.item.a  = s_tdata[7:0];
    ctl.item.b  = s_tdata[15:8];
    ctl.item.w  = s_tdata[31:16];
    ctl.sn      = s_tdata[39:32];
  end

  assign ge_c[0]    = 1'b0;
  assign seen_c[0]  = 1'b0;
  assign found_c[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    speq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (CNT_W'(i) < count),
      .head      (i == 0),
      .ge_in     (ge_c[i]),
      .ge_out    (ge_c[i+1]),
      .seen_in   (seen_c[i]),
      .seen_out  (seen_c[i+1]),
      .found_in  (found_c[i]),
      .found_out (found_c[i+1]),
      .left      ((i == 0) ? edge_t'('0) : slot[(i == 0) ? 0 : i-1]),
      .right     ((i == DEPTH-1) ? edge_t'('0) : slot[(i == DEPTH-1) ? i : i+1]),
      .hold      (slot[i])
    );
  end

  always_comb begin
    count_next = count;
    res_edge   = '0;
    res_stat   = ST_OK;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.rem) begin
      if (seen_c[DEPTH]) begin
        count_next = count - CNT_W'(1);
        res_edge   = found_c[DEPTH];
      end else begin
        res_stat = ST_EMPTY;
      end
    end else if (s_tuser == CMD_INSERT) begin
      res_stat = ST_FULL;
    end
    res_fill = FILL_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, res_fill, res_edge.w, res_edge.b, res_edge.a};
      m_tuser <= res_stat;
    end
  end

endmodule
`default_nettype wire

@@ src/speq_cell.sv @@
// One queue slot: holds an edge, compares it against the command, shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module speq_cell (
  input  wire logic          clk,
  input  wire speq_pkg::ctl_t ctl,
  input  wire logic          occ,
  input  wire logic          head,
  input  wire logic          ge_in,
  output logic               ge_out,
  input  wire logic          seen_in,
  output logic               seen_out,
  input  wire speq_pkg::edge_t found_in,
  output speq_pkg::edge_t    found_out,
  input  wire speq_pkg::edge_t left,
  input  wire speq_pkg::edge_t right,
  output speq_pkg::edge_t    hold
);
  import speq_pkg::*;

  logic  match;
  edge_t hold_next;

  assign ge_out   = !occ || (hold.w >= ctl.item.w);
  assign match    = occ && (ctl.pop_min ? head
                                         : (hold.a == ctl.sn || hold.b == ctl.sn));
  assign seen_out = seen_in || match;

  always_comb begin
    if (seen_in) begin
      found_out = found_in;
    end else if (match) begin
      found_out = hold;
    end else begin
      found_out = '0;
    end
  end

  always_comb begin
    hold_next = hold;
    if (ctl.ins) begin
      if (ge_in) begin
        hold_next = left;
      end else if (ge_out) begin
        hold_next = ctl.item;
      end
    end else if (ctl.rem && seen_out) begin
      hold_next = right;
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
  end

endmodule
`default_nettype wire

@@ src/speq_checker.sv @@
// Port checker for the edge queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module speq_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic [speq_pkg::IN_W-1:0]   s_tdata,
  input wire logic [speq_pkg::CMD_W-1:0]  s_tuser,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [speq_pkg::OUT_W-1:0]  m_tdata,
  input wire logic [speq_pkg::STAT_W-1:0] m_tuser
);
  import speq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_resp: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted word produced no result");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[36:32] <= FILL_W'(DEPTH) && m_tuser != 2'd3)
    else $error("fill or status out of range");

  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[36:32] == FILL_W'(DEPTH)
                                        && m_tdata[31:0] == '0)
    else $error("full status with queue not full");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[31:0] == '0)
    else $error("empty status carries an edge");

endmodule

bind sorted_edge_priority_queue speq_checker u_speq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
